### rtl/core/interval_action_scheduler_defines.svh
// ---------------------------------------------------------------------------
// interval action scheduler assertion macros
// shared assertion forms, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef INTERVAL_ACTION_SCHEDULER_DEFINES_SVH
`define INTERVAL_ACTION_SCHEDULER_DEFINES_SVH

// invariant checked at every edge out of reset
`define IAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define IAS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/ias_pkg.sv
// ---------------------------------------------------------------------------
// ias_pkg
// types, constants and helpers shared by the interval action scheduler
// ---------------------------------------------------------------------------
package ias_pkg;

  localparam int SLOTS     = 4;
  localparam int MAX_STEPS = SLOTS - 1;
  localparam int IDX_W     = 2;
  localparam int LEN_W     = $clog2(SLOTS + 1);
  localparam int STEP_W    = 2;
  localparam int TIME_W    = 32;
  localparam int CHILD_W   = 3;
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = 2;

  localparam logic [CHILD_W-1:0] NO_CHILD = CHILD_W'(4);

  typedef enum logic [2:0] {
    OP_TIME,
    OP_SCHED,
    OP_DESCHED,
    OP_STOP,
    OP_SETUP,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SCHED,
    MODE_CHILD_SCHED,
    MODE_RUN,
    MODE_CHILD_RUN,
    MODE_PEND
  } mode_e;

  typedef enum logic [1:0] {
    RES_ACK,
    RES_START,
    RES_TICK,
    RES_STOP
  } res_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   slot;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  interval;
    logic [TIME_W-1:0]  duration;
    logic [TIME_W-1:0]  tick_after;
    logic [CHILD_W-1:0] child;
    logic               keep;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  function automatic logic link_ok(input logic [CHILD_W-1:0] c);
    return (c != NO_CHILD) && (c < CHILD_W'(SLOTS));
  endfunction

endpackage

### rtl/core/interval_action_scheduler.sv
// ---------------------------------------------------------------------------
// interval_action_scheduler
// action slot scheduler: commands and time passes produce event items
// ---------------------------------------------------------------------------
// a command goes from the queue through the decode state to its acknowledge; schedule and
// deschedule pass through the chain state first, with one step per chained child
// a time pass visits each listed slot (start, or tick and stop checks, a chain step per child),
// then sweeps every slot for removal, walking each removed slot's chain, then emits pass-done
// the single sequencer in ias_back takes one item at a time; a two-entry queue buffers input
// reset is asynchronous: all slots non-active, settings zero, no child links, list empty
module interval_action_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   kind_i,
  input  logic [ias_pkg::IDX_W-1:0]    slot_i,
  input  logic [ias_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [ias_pkg::TIME_W-1:0]   interval_ms_i,
  input  logic [ias_pkg::TIME_W-1:0]   duration_ms_i,
  input  logic [ias_pkg::TIME_W-1:0]   tick_after_ms_i,
  input  logic [ias_pkg::CHILD_W-1:0]  child_slot_i,
  input  logic                         keep_after_stop_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   event_res_o,
  output logic [ias_pkg::IDX_W-1:0]    event_slot_o,
  output logic                         is_child_o,
  output logic                         accepted_o,
  output logic                         last_o
);

  ias_pkg::queue_t queue;
  logic            pop;

  ias_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .slot_i            (slot_i),
    .now_ms_i          (now_ms_i),
    .interval_ms_i     (interval_ms_i),
    .duration_ms_i     (duration_ms_i),
    .tick_after_ms_i   (tick_after_ms_i),
    .child_slot_i      (child_slot_i),
    .keep_after_stop_i (keep_after_stop_i),
    .queue_o           (queue),
    .pop_i             (pop)
  );

  ias_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_i      (queue),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .event_slot_o (event_slot_o),
    .is_child_o   (is_child_o),
    .accepted_o   (accepted_o),
    .last_o       (last_o)
  );

endmodule

### rtl/core/ias_front.sv
// ---------------------------------------------------------------------------
// ias_front
// accepts items, decodes the kind and buffers them in a two-entry queue
// ---------------------------------------------------------------------------
`include "interval_action_scheduler_defines.svh"

module ias_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    kind_i,
  input  logic [ias_pkg::IDX_W-1:0]     slot_i,
  input  logic [ias_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [ias_pkg::TIME_W-1:0]    interval_ms_i,
  input  logic [ias_pkg::TIME_W-1:0]    duration_ms_i,
  input  logic [ias_pkg::TIME_W-1:0]    tick_after_ms_i,
  input  logic [ias_pkg::CHILD_W-1:0]   child_slot_i,
  input  logic                          keep_after_stop_i,
  output ias_pkg::queue_t               queue_o,
  input  logic                          pop_i
);

  ias_pkg::item_t              ent_q [ias_pkg::QDEPTH];
  ias_pkg::item_t              new_item;
  logic                        wr_ptr_q, rd_ptr_q;
  logic [ias_pkg::QCNT_W-1:0]  cnt_q;
  logic                        push, pop;

  always_comb begin
    unique case (kind_i)
      3'd0:    new_item.op = ias_pkg::OP_TIME;
      3'd1:    new_item.op = ias_pkg::OP_SCHED;
      3'd2:    new_item.op = ias_pkg::OP_DESCHED;
      3'd3:    new_item.op = ias_pkg::OP_STOP;
      3'd4:    new_item.op = ias_pkg::OP_SETUP;
      default: new_item.op = ias_pkg::OP_BAD;
    endcase
    new_item.slot       = slot_i;
    new_item.now        = now_ms_i;
    new_item.interval   = interval_ms_i;
    new_item.duration   = duration_ms_i;
    new_item.tick_after = tick_after_ms_i;
    new_item.child      = child_slot_i;
    new_item.keep       = keep_after_stop_i;
  end

  assign in_stall_o    = (cnt_q == ias_pkg::QCNT_W'(ias_pkg::QDEPTH));
  assign push          = in_valid_i && !in_stall_o;
  assign pop           = pop_i && (cnt_q != '0);
  assign queue_o.valid = (cnt_q != '0);
  assign queue_o.item  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        ent_q[wr_ptr_q] <= new_item;
        wr_ptr_q        <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `IAS_ASSERT(a_queue_bound, cnt_q <= ias_pkg::QCNT_W'(ias_pkg::QDEPTH), "queue count overflow")

endmodule

### rtl/core/ias_back.sv
// ---------------------------------------------------------------------------
// ias_back
// sequencer that executes commands and time passes and emits result items
// ---------------------------------------------------------------------------
`include "interval_action_scheduler_defines.svh"

module ias_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ias_pkg::queue_t             queue_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  event_res_o,
  output logic [ias_pkg::IDX_W-1:0]   event_slot_o,
  output logic                        is_child_o,
  output logic                        accepted_o,
  output logic                        last_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_CHAIN,
    S_ACK,
    S_VISIT,
    S_TICK,
    S_STOPCHK,
    S_START_CH,
    S_STOP_CH,
    S_REMOVE,
    S_DONE
  } state_e;

  state_e                          state_q;
  ias_pkg::item_t                  cur_q;
  ias_pkg::mode_e                  mode_q     [ias_pkg::SLOTS];
  ias_pkg::mode_e                  chain_mode_q;
  logic [ias_pkg::TIME_W-1:0]      run_q      [ias_pkg::SLOTS];
  logic [ias_pkg::TIME_W-1:0]      stop_t_q   [ias_pkg::SLOTS];
  logic [ias_pkg::TIME_W-1:0]      intv_q     [ias_pkg::SLOTS];
  logic [ias_pkg::TIME_W-1:0]      dur_q      [ias_pkg::SLOTS];
  logic [ias_pkg::TIME_W-1:0]      tick_q     [ias_pkg::SLOTS];
  logic [ias_pkg::CHILD_W-1:0]     link_q     [ias_pkg::SLOTS];
  logic [ias_pkg::IDX_W-1:0]       order_q    [ias_pkg::SLOTS];
  logic [ias_pkg::SLOTS-1:0]       want_q, rm_q, keep_q;
  logic [ias_pkg::LEN_W-1:0]       len_q, rj_q;
  logic [ias_pkg::IDX_W-1:0]       idx_q;
  logic [ias_pkg::CHILD_W-1:0]     cur_c_q;
  logic [ias_pkg::STEP_W-1:0]      steps_q;
  logic                            ret_ack_q, ok_q;

  logic                            out_valid_q, child_q, acc_q, last_q;
  ias_pkg::res_e                   res_q;
  logic [ias_pkg::IDX_W-1:0]       eslot_q;

  logic [ias_pkg::IDX_W-1:0]       s_idx, a_idx, j_idx, key, pos, c_idx;
  logic                            found, link_go, out_free, can_go, tick_go, stop_go, last_visit;
  logic                            fire;
  logic [ias_pkg::TIME_W-1:0]      dstop, drun;

  always_comb begin
    s_idx = cur_q.slot;
    a_idx = order_q[idx_q];
    j_idx = rj_q[ias_pkg::IDX_W-1:0];
    c_idx = cur_c_q[ias_pkg::IDX_W-1:0];
    key   = (state_q == S_REMOVE) ? j_idx : s_idx;
    found = 1'b0;
    pos   = '0;
    for (int k = ias_pkg::SLOTS - 1; k >= 0; k--) begin
      if (ias_pkg::LEN_W'(k) < len_q && order_q[k] == key) begin
        found = 1'b1;
        pos   = ias_pkg::IDX_W'(k);
      end
    end
    link_go  = (steps_q < ias_pkg::STEP_W'(ias_pkg::MAX_STEPS)) && ias_pkg::link_ok(cur_c_q);
    out_free = !out_valid_q || !out_stall_i;
    dstop    = cur_q.now - stop_t_q[a_idx];
    drun     = cur_q.now - run_q[a_idx];
    can_go   = !want_q[a_idx] && (mode_q[a_idx] != ias_pkg::MODE_RUN) &&
               !((intv_q[a_idx] != '0) && (stop_t_q[a_idx] != '0) && (dstop < intv_q[a_idx]));
    tick_go  = (mode_q[a_idx] == ias_pkg::MODE_RUN) && (drun > tick_q[a_idx]);
    stop_go  = want_q[a_idx] ||
               ((mode_q[a_idx] == ias_pkg::MODE_RUN) && (dur_q[a_idx] != '0) &&
                (run_q[a_idx] != '0) && (drun >= dur_q[a_idx]));
    last_visit = (ias_pkg::LEN_W'(idx_q) + ias_pkg::LEN_W'(1)) == len_q;
    fire     = out_free &&
               ((state_q == S_ACK) || (state_q == S_DONE) || (state_q == S_STOP_CH) ||
                ((state_q == S_VISIT) && can_go) || ((state_q == S_TICK) && tick_go) ||
                ((state_q == S_START_CH) && link_go));
  end

  assign pop_o        = (state_q == S_IDLE) && queue_i.valid;
  assign out_valid_o  = out_valid_q;
  assign event_res_o  = res_q;
  assign event_slot_o = eslot_q;
  assign is_child_o   = child_q;
  assign accepted_o   = acc_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      want_q       <= '0;
      rm_q         <= '0;
      keep_q       <= '0;
      len_q        <= '0;
      rj_q         <= '0;
      idx_q        <= '0;
      steps_q      <= '0;
      cur_c_q      <= ias_pkg::NO_CHILD;
      ret_ack_q    <= 1'b1;
      ok_q         <= 1'b0;
      chain_mode_q <= ias_pkg::MODE_IDLE;
      for (int k = 0; k < ias_pkg::SLOTS; k++) begin
        mode_q[k]   <= ias_pkg::MODE_IDLE;
        run_q[k]    <= '0;
        stop_t_q[k] <= '0;
        intv_q[k]   <= '0;
        dur_q[k]    <= '0;
        tick_q[k]   <= '0;
        link_q[k]   <= ias_pkg::NO_CHILD;
      end
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (queue_i.valid) begin
            cur_q   <= queue_i.item;
            state_q <= S_CMD;
          end
        end
        S_CMD: begin
          steps_q   <= '0;
          ret_ack_q <= 1'b1;
          unique case (cur_q.op)
            ias_pkg::OP_TIME: begin
              idx_q   <= '0;
              rj_q    <= '0;
              state_q <= (len_q == '0) ? S_REMOVE : S_VISIT;
            end
            ias_pkg::OP_SCHED: begin
              if (!found && mode_q[s_idx] == ias_pkg::MODE_IDLE &&
                  len_q < ias_pkg::LEN_W'(ias_pkg::SLOTS)) begin
                ok_q                                     <= 1'b1;
                mode_q[s_idx]                            <= ias_pkg::MODE_SCHED;
                order_q[len_q[ias_pkg::IDX_W-1:0]]       <= s_idx;
                len_q                                    <= len_q + 1'b1;
                cur_c_q                                  <= link_q[s_idx];
                chain_mode_q                             <= ias_pkg::MODE_CHILD_SCHED;
                state_q                                  <= S_CHAIN;
              end else begin
                ok_q    <= 1'b0;
                state_q <= S_ACK;
              end
            end
            ias_pkg::OP_DESCHED: begin
              if (found && mode_q[s_idx] != ias_pkg::MODE_RUN) begin
                ok_q          <= 1'b1;
                mode_q[s_idx] <= ias_pkg::MODE_IDLE;
                for (int k = 0; k < ias_pkg::SLOTS - 1; k++) begin
                  if (ias_pkg::IDX_W'(k) >= pos) order_q[k] <= order_q[k+1];
                end
                len_q         <= len_q - 1'b1;
                cur_c_q       <= link_q[s_idx];
                chain_mode_q  <= ias_pkg::MODE_IDLE;
                state_q       <= S_CHAIN;
              end else begin
                ok_q    <= 1'b0;
                state_q <= S_ACK;
              end
            end
            ias_pkg::OP_STOP: begin
              ok_q    <= found;
              state_q <= S_ACK;
              if (found) want_q[s_idx] <= 1'b1;
            end
            ias_pkg::OP_SETUP: begin
              ok_q          <= 1'b1;
              intv_q[s_idx] <= cur_q.interval;
              dur_q[s_idx]  <= cur_q.duration;
              tick_q[s_idx] <= cur_q.tick_after;
              link_q[s_idx] <= cur_q.child;
              keep_q[s_idx] <= cur_q.keep;
              state_q       <= S_ACK;
            end
            default: begin
              ok_q    <= 1'b0;
              state_q <= S_ACK;
            end
          endcase
        end
        S_CHAIN: begin
          if (link_go) begin
            mode_q[c_idx] <= chain_mode_q;
            cur_c_q       <= link_q[c_idx];
            steps_q       <= steps_q + 1'b1;
          end else begin
            state_q <= ret_ack_q ? S_ACK : S_REMOVE;
          end
        end
        S_ACK: begin
          if (out_free) begin
            res_q       <= ias_pkg::RES_ACK;
            eslot_q     <= s_idx;
            child_q     <= 1'b0;
            acc_q       <= ok_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_VISIT: begin
          steps_q <= '0;
          cur_c_q <= link_q[a_idx];
          if (can_go) begin
            if (out_free) begin
              res_q         <= ias_pkg::RES_START;
              eslot_q       <= a_idx;
              child_q       <= 1'b0;
              acc_q         <= 1'b1;
              last_q        <= 1'b0;
              mode_q[a_idx] <= ias_pkg::MODE_RUN;
              run_q[a_idx]  <= cur_q.now;
              state_q       <= S_START_CH;
            end
          end else begin
            state_q <= S_TICK;
          end
        end
        S_TICK: begin
          if (!tick_go) begin
            state_q <= S_STOPCHK;
          end else if (out_free) begin
            res_q       <= ias_pkg::RES_TICK;
            eslot_q     <= a_idx;
            child_q     <= 1'b0;
            acc_q       <= 1'b1;
            last_q      <= 1'b0;
            state_q     <= S_STOPCHK;
          end
        end
        S_STOPCHK: begin
          if (stop_go) begin
            state_q <= S_STOP_CH;
          end else if (last_visit) begin
            state_q <= S_REMOVE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_VISIT;
          end
        end
        S_START_CH: begin
          if (link_go) begin
            if (out_free) begin
              res_q         <= ias_pkg::RES_START;
              eslot_q       <= c_idx;
              child_q       <= 1'b1;
              acc_q         <= 1'b1;
              last_q        <= 1'b0;
              mode_q[c_idx] <= ias_pkg::MODE_CHILD_RUN;
              cur_c_q       <= link_q[c_idx];
              steps_q       <= steps_q + 1'b1;
            end
          end else if (last_visit) begin
            state_q <= S_REMOVE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_VISIT;
          end
        end
        S_STOP_CH: begin
          if (out_free) begin
            res_q       <= ias_pkg::RES_STOP;
            acc_q       <= 1'b1;
            last_q      <= 1'b0;
            if (link_go) begin
              eslot_q       <= c_idx;
              child_q       <= 1'b1;
              mode_q[c_idx] <= ias_pkg::MODE_IDLE;
              cur_c_q       <= link_q[c_idx];
              steps_q       <= steps_q + 1'b1;
            end else begin
              eslot_q         <= a_idx;
              child_q         <= 1'b0;
              stop_t_q[a_idx] <= cur_q.now;
              mode_q[a_idx]   <= ias_pkg::MODE_PEND;
              rm_q[a_idx]     <= !keep_q[a_idx];
              want_q[a_idx]   <= 1'b0;
              if (last_visit) begin
                state_q <= S_REMOVE;
              end else begin
                idx_q   <= idx_q + 1'b1;
                state_q <= S_VISIT;
              end
            end
          end
        end
        S_REMOVE: begin
          if (rj_q == ias_pkg::LEN_W'(ias_pkg::SLOTS)) begin
            state_q <= S_DONE;
          end else begin
            rj_q <= rj_q + 1'b1;
            if (rm_q[j_idx]) begin
              rm_q[j_idx] <= 1'b0;
              if (found && mode_q[j_idx] != ias_pkg::MODE_RUN) begin
                mode_q[j_idx] <= ias_pkg::MODE_IDLE;
                for (int k = 0; k < ias_pkg::SLOTS - 1; k++) begin
                  if (ias_pkg::IDX_W'(k) >= pos) order_q[k] <= order_q[k+1];
                end
                len_q        <= len_q - 1'b1;
                cur_c_q      <= link_q[j_idx];
                steps_q      <= '0;
                chain_mode_q <= ias_pkg::MODE_IDLE;
                ret_ack_q    <= 1'b0;
                state_q      <= S_CHAIN;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_q       <= ias_pkg::RES_ACK;
            eslot_q     <= '0;
            child_q     <= 1'b0;
            acc_q       <= 1'b1;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `IAS_ASSERT(a_len_bound, len_q <= ias_pkg::LEN_W'(ias_pkg::SLOTS), "schedule list overflow")
  `IAS_ASSERT(a_marks_clear, (state_q == S_IDLE) |-> (rm_q == '0), "removal mark left after pass")
  `IAS_ASSERT_NEXT(a_done_last, (state_q == S_DONE) && out_free, out_valid_q && last_q, "pass end not last")

endmodule
